>>> rtl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// shared types, constants and color helpers of the led strip pattern engine
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int PIXEL_COUNT_DEFAULT = 8;
   localparam int CHAN_W              = 7;
   localparam int INDEX_OUT_W         = 3;
   localparam int MODE_W              = 4;
   localparam int CSR_ADDR_W          = 5;
   localparam int CSR_DATA_W          = 32;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

   localparam color_type COLOR_BLACK   = '{red: 7'h00, green: 7'h00, blue: 7'h00};
   localparam color_type COLOR_MAGENTA = '{red: 7'h7F, green: 7'h00, blue: 7'h7F};
   localparam color_type COLOR_PURPLE  = '{red: 7'h7F, green: 7'h00, blue: 7'h45};
   localparam color_type COLOR_BLUE    = '{red: 7'h00, green: 7'h00, blue: 7'h7F};

   typedef enum logic [MODE_W-1:0] {
      PAT_BLANK     = 4'd0,
      PAT_SOLID     = 4'd1,
      PAT_FLASH     = 4'd2,
      PAT_FADE      = 4'd3,
      PAT_DUAL      = 4'd4,
      PAT_WIPE_DOWN = 4'd5,
      PAT_WIPE_UP   = 4'd6,
      PAT_RAINBOW   = 4'd7,
      PAT_BANDS     = 4'd8
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE            = 3'd0,
      REG_PRIMARY_RED     = 3'd1,
      REG_PRIMARY_GREEN   = 3'd2,
      REG_PRIMARY_BLUE    = 3'd3,
      REG_SECONDARY_RED   = 3'd4,
      REG_SECONDARY_GREEN = 3'd5,
      REG_SECONDARY_BLUE  = 3'd6
   } csr_index_type;

   // settings the pixel engine reads, held by the register block
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      color_type         primary;
      color_type         secondary;
   } cfg_type;

   // one queued tick
   typedef struct packed {
      logic restart;
   } tick_type;

   function automatic logic [CHAN_W-1:0] step_channel(input logic [CHAN_W-1:0] s,
                                                      input logic [CHAN_W-1:0] e);
      logic [CHAN_W:0] s_up;
      logic [CHAN_W:0] e_up;
      logic [CHAN_W-1:0] r;
      s_up = {1'b0, s} + (CHAN_W+1)'(2);
      e_up = {1'b0, e} + (CHAN_W+1)'(2);
      if (s_up < {1'b0, e}) begin
         r = s_up[CHAN_W-1:0];
      end else if ({1'b0, s} > e_up) begin
         r = s - CHAN_W'(2);
      end else begin
         r = e;
      end
      return r;
   endfunction

   function automatic color_type step_color(input color_type base, input color_type target);
      color_type r;
      r.red   = step_channel(base.red, target.red);
      r.green = step_channel(base.green, target.green);
      r.blue  = step_channel(base.blue, target.blue);
      return r;
   endfunction

   // red, orange, yellow, green, blue, cyan, magenta, purple
   function automatic color_type rainbow_color(input logic [2:0] sel);
      color_type r;
      unique case (sel)
         3'd0: r = '{red: 7'h7F, green: 7'h00, blue: 7'h00};
         3'd1: r = '{red: 7'h7F, green: 7'h20, blue: 7'h00};
         3'd2: r = '{red: 7'h7F, green: 7'h7F, blue: 7'h00};
         3'd3: r = '{red: 7'h00, green: 7'h7F, blue: 7'h00};
         3'd4: r = '{red: 7'h00, green: 7'h00, blue: 7'h7F};
         3'd5: r = '{red: 7'h00, green: 7'h7F, blue: 7'h7F};
         3'd6: r = '{red: 7'h7F, green: 7'h00, blue: 7'h7F};
         default: r = '{red: 7'h7F, green: 7'h00, blue: 7'h45};
      endcase
      return r;
   endfunction

endpackage

>>> rtl/lsp_req_if.sv
// ----------------------------------------------------------------------------
// lsp_req_if
// tick request channel: valid, ready and the restart flag
// ----------------------------------------------------------------------------
interface lsp_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

>>> rtl/lsp_rsp_if.sv
// ----------------------------------------------------------------------------
// lsp_rsp_if
// pixel result channel: valid, ready and one pixel of the frame
// ----------------------------------------------------------------------------
interface lsp_rsp_if import lsp_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [INDEX_OUT_W-1:0] pixel_index;
   logic [CHAN_W-1:0]      red;
   logic [CHAN_W-1:0]      green;
   logic [CHAN_W-1:0]      blue;
   logic                   last_pixel;

   modport source (output valid, output pixel_index, output red, output green,
                   output blue, output last_pixel, input ready);
   modport sink (input valid, input pixel_index, input red, input green,
                 input blue, input last_pixel, output ready);
endinterface

>>> rtl/lsp_csr.sv
// ----------------------------------------------------------------------------
// lsp_csr
// apb register block holding the pattern mode and the two colors
// ----------------------------------------------------------------------------
module lsp_csr import lsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type reg_sel;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_sel = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MODE:            cfg_in.mode            = pwdata[MODE_W-1:0];
            REG_PRIMARY_RED:     cfg_in.primary.red     = pwdata[CHAN_W-1:0];
            REG_PRIMARY_GREEN:   cfg_in.primary.green   = pwdata[CHAN_W-1:0];
            REG_PRIMARY_BLUE:    cfg_in.primary.blue    = pwdata[CHAN_W-1:0];
            REG_SECONDARY_RED:   cfg_in.secondary.red   = pwdata[CHAN_W-1:0];
            REG_SECONDARY_GREEN: cfg_in.secondary.green = pwdata[CHAN_W-1:0];
            REG_SECONDARY_BLUE:  cfg_in.secondary.blue  = pwdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         REG_MODE:            prdata = CSR_DATA_W'(cfg_ff.mode);
         REG_PRIMARY_RED:     prdata = CSR_DATA_W'(cfg_ff.primary.red);
         REG_PRIMARY_GREEN:   prdata = CSR_DATA_W'(cfg_ff.primary.green);
         REG_PRIMARY_BLUE:    prdata = CSR_DATA_W'(cfg_ff.primary.blue);
         REG_SECONDARY_RED:   prdata = CSR_DATA_W'(cfg_ff.secondary.red);
         REG_SECONDARY_GREEN: prdata = CSR_DATA_W'(cfg_ff.secondary.green);
         REG_SECONDARY_BLUE:  prdata = CSR_DATA_W'(cfg_ff.secondary.blue);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= PAT_SOLID;
         cfg_ff.primary   <= '{red: 7'h7F, green: 7'h00, blue: 7'h00};
         cfg_ff.secondary <= '{red: 7'h00, green: 7'h7F, blue: 7'h7F};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/lsp_front.sv
// ----------------------------------------------------------------------------
// lsp_front
// accepts tick requests and holds them in a two-entry queue for the engine
// ----------------------------------------------------------------------------
module lsp_front import lsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lsp_req_if.sink  req_chan,
   output logic     deq_valid,
   input  logic     deq_ready,
   output tick_type deq_item
);

   tick_type   queue_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign deq_valid      = (count_ff != 2'd0);
   assign pop            = deq_valid && deq_ready;
   assign deq_item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff].restart <= req_chan.restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/lsp_back.sv
// ----------------------------------------------------------------------------
// lsp_back
// pixel engine: sweeps the frame memory once per tick, updates each pixel
// for the current mode and emits it through an output register
// ----------------------------------------------------------------------------
module lsp_back import lsp_pkg::*; #(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       deq_valid,
   output logic       deq_ready,
   input  tick_type   deq_item,
   lsp_rsp_if.source  rsp_chan
);

   localparam int IDX_W  = $clog2(PIXEL_COUNT);
   localparam int CNT_W  = IDX_W + 1;
   localparam int BAND_1 = (3 * PIXEL_COUNT) / 8;
   localparam int BAND_2 = BAND_1 + PIXEL_COUNT / 4;
   localparam int BAND_3 = BAND_2 + (3 * PIXEL_COUNT) / 8;
   localparam logic [2:0] RAINBOW_STEP = 3'((PIXEL_COUNT - 1) % 8);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SWEEP = 2'b10
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      color_type        color;
      logic             last;
   } pixel_type;

   // frame memory, valid bits make unwritten pixels read black
   color_type        frame_mem_ff [PIXEL_COUNT];
   logic             valid_ff [PIXEL_COUNT];
   color_type        rd_data_ff;
   logic             rd_valid_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   color_type        wr_data;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             b_valid_ff, b_valid_in;
   logic [IDX_W-1:0] b_idx_ff, b_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pixel_type        rsp_data_ff, rsp_data_in;

   logic             strobe_phase_ff, strobe_phase_in;
   color_type        fade_target_ff, fade_target_in;
   color_type        fade_next_ff, fade_next_in;
   logic             pending_ff, pending_in;
   logic             tick_restart_ff, tick_restart_in;
   logic [IDX_W-1:0] wipe_pos_ff, wipe_pos_in;
   logic [2:0]       rainbow_off_ff, rainbow_off_in;

   logic             adv;
   logic             issue;
   logic             pend_eff;
   logic             fade_mode;
   logic             wipe_mode;
   logic [IDX_W-1:0] lit_idx;
   logic             is_lit;
   logic [CNT_W-1:0] b_idx_ext;
   color_type        old_color;
   color_type        second_color;
   color_type        fade_base;
   color_type        fade_step;
   color_type        upd_color;
   color_type        out_color;

   assign adv       = !rsp_valid_ff || rsp_chan.ready;
   assign issue     = (cnt_ff < CNT_W'(PIXEL_COUNT));
   assign rd_addr   = cnt_ff[IDX_W-1:0];
   assign fade_mode = (cfg.mode == PAT_FADE) || (cfg.mode == PAT_DUAL);
   assign wipe_mode = (cfg.mode == PAT_WIPE_DOWN) || (cfg.mode == PAT_WIPE_UP);
   assign pend_eff  = pending_ff || deq_item.restart;
   assign b_idx_ext = {1'b0, b_idx_ff};

   // per-pixel update
   always_comb begin
      old_color    = rd_valid_ff ? rd_data_ff : COLOR_BLACK;
      second_color = (cfg.mode == PAT_FADE) ? COLOR_BLACK : cfg.secondary;
      fade_base    = tick_restart_ff ? cfg.primary : old_color;
      fade_step    = step_color(fade_base, fade_target_ff);
      lit_idx      = (cfg.mode == PAT_WIPE_DOWN) ? wipe_pos_ff : LAST_IDX - wipe_pos_ff;
      is_lit       = wipe_mode && (b_idx_ff == lit_idx);
      unique case (cfg.mode)
         PAT_BLANK: upd_color = COLOR_BLACK;
         PAT_SOLID: upd_color = cfg.primary;
         PAT_FLASH: upd_color = strobe_phase_ff ? cfg.primary : COLOR_BLACK;
         PAT_FADE, PAT_DUAL: begin
            upd_color = (b_idx_ff == '0) ? fade_step : fade_next_ff;
         end
         PAT_WIPE_DOWN, PAT_WIPE_UP: begin
            upd_color = ((wipe_pos_ff == '0) || is_lit) ? COLOR_BLACK : old_color;
         end
         PAT_RAINBOW: upd_color = rainbow_color(rainbow_off_ff + 3'(b_idx_ff));
         PAT_BANDS: begin
            priority if (b_idx_ext < CNT_W'(BAND_1)) upd_color = COLOR_MAGENTA;
            else if (b_idx_ext < CNT_W'(BAND_2))     upd_color = COLOR_PURPLE;
            else if (b_idx_ext < CNT_W'(BAND_3))     upd_color = COLOR_BLUE;
            else                                     upd_color = old_color;
         end
         default: upd_color = old_color;
      endcase
      out_color = is_lit ? cfg.primary : upd_color;
      wr_data   = upd_color;
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      b_valid_in      = b_valid_ff;
      b_idx_in        = b_idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      strobe_phase_in = strobe_phase_ff;
      fade_target_in  = fade_target_ff;
      fade_next_in    = fade_next_ff;
      pending_in      = pending_ff;
      tick_restart_in = tick_restart_ff;
      wipe_pos_in     = wipe_pos_ff;
      rainbow_off_in  = rainbow_off_ff;
      deq_ready       = 1'b0;
      rd_en           = 1'b0;
      wr_en           = 1'b0;

      if (adv) begin
         rsp_valid_in      = b_valid_ff;
         rsp_data_in.idx   = b_idx_ff;
         rsp_data_in.color = out_color;
         rsp_data_in.last  = (b_idx_ff == LAST_IDX);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (deq_valid) begin
               deq_ready       = 1'b1;
               state_in        = ST_SWEEP;
               cnt_in          = '0;
               tick_restart_in = 1'b0;
               pending_in      = pend_eff;
               if (fade_mode && pend_eff) begin
                  pending_in      = 1'b0;
                  tick_restart_in = 1'b1;
                  fade_target_in  = second_color;
               end
            end
         end
         ST_SWEEP: begin
            if (adv) begin
               rd_en      = issue;
               b_valid_in = issue;
               b_idx_in   = rd_addr;
               if (issue) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (b_valid_ff) begin
                  wr_en = 1'b1;
                  if (fade_mode && (b_idx_ff == '0)) begin
                     fade_next_in = fade_step;
                     if (fade_step == fade_target_ff) begin
                        fade_target_in = (fade_target_ff == cfg.primary) ? second_color
                                                                         : cfg.primary;
                     end
                  end
                  if (b_idx_ff == LAST_IDX) begin
                     state_in = ST_IDLE;
                     if (cfg.mode == PAT_FLASH) begin
                        strobe_phase_in = ~strobe_phase_ff;
                     end
                     if (wipe_mode) begin
                        wipe_pos_in = (wipe_pos_ff == LAST_IDX) ? '0
                                                                : wipe_pos_ff + IDX_W'(1);
                     end
                     if (cfg.mode == PAT_RAINBOW) begin
                        rainbow_off_in = rainbow_off_ff + RAINBOW_STEP;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_mem_ff[rd_addr];
      end
      if (wr_en) begin
         frame_mem_ff[b_idx_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIXEL_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[b_idx_ff] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         b_valid_ff      <= 1'b0;
         b_idx_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         strobe_phase_ff <= 1'b0;
         fade_target_ff  <= COLOR_BLACK;
         pending_ff      <= 1'b0;
         tick_restart_ff <= 1'b0;
         wipe_pos_ff     <= '0;
         rainbow_off_ff  <= 3'd0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         b_valid_ff      <= b_valid_in;
         b_idx_ff        <= b_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
         strobe_phase_ff <= strobe_phase_in;
         fade_target_ff  <= fade_target_in;
         pending_ff      <= pending_in;
         tick_restart_ff <= tick_restart_in;
         wipe_pos_ff     <= wipe_pos_in;
         rainbow_off_ff  <= rainbow_off_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      fade_next_ff <= fade_next_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_index = INDEX_OUT_W'(rsp_data_ff.idx);
   assign rsp_chan.red         = rsp_data_ff.color.red;
   assign rsp_chan.green       = rsp_data_ff.color.green;
   assign rsp_chan.blue        = rsp_data_ff.color.blue;
   assign rsp_chan.last_pixel  = rsp_data_ff.last;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("engine state not one-hot");

   a_stage_in_sweep: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (state_ff == ST_SWEEP))
      else $error("pixel in flight outside a sweep");

   a_counter_leads: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (cnt_ff == b_idx_ext + CNT_W'(1)))
      else $error("read counter out of step with pixel stage");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_pixel)
         |-> (rsp_chan.pixel_index == INDEX_OUT_W'(PIXEL_COUNT - 1)))
      else $error("last pixel flag on wrong pixel");
`endif

endmodule

>>> rtl/led_strip_pattern_engine_core.sv
// ----------------------------------------------------------------------------
// led_strip_pattern_engine_core
// animation tick in, one full frame of 7-bit rgb pixels out per tick
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_chan  in         valid/ready        restart
//  rsp_chan  out        valid/ready        pixel_index, red, green, blue, last_pixel
//  csr (apb) in         psel/penable/pready paddr, pwdata, prdata
//
//  a tick pulls the request from the queue, reads each pixel from the frame memory
//  and registers it for output, one pixel per cycle while rsp_chan is not stalled,
//  set by the single read port of the frame memory
//  requests queue up to two deep while the engine sweeps the previous frame
//  reset is synchronous, active high; the frame store reads black afterwards
//  through per-pixel valid bits, so no clearing pass is needed
//  a stalled rsp_chan holds the pixel sweep in place, nothing is dropped
// ----------------------------------------------------------------------------
module led_strip_pattern_engine_core import lsp_pkg::*; #(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   lsp_req_if.sink               req_chan,
   lsp_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // settings for the engine; the user keeps them stable while a tick is in flight, the block does not enforce it
   cfg_type  cfg;

   // queue to engine hand-off
   logic     deq_valid;
   logic     deq_ready;
   tick_type deq_item;

   lsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front: takes tick requests as long as the queue has room
   lsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_item  (deq_item)
   );

   // back: per-tick state update and pixel sweep over the frame memory
   lsp_back #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_item  (deq_item),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// frame-level check of the led strip pattern engine core: animation ticks go
// in on the request channel, every pixel of each frame is compared against a
// cycle-free software image of the frame store, with random stalls on both
// channels and apb register writes between bursts of ticks
// ----------------------------------------------------------------------------
module testbench;
   import lsp_pkg::*;

   localparam int PIXELS       = PIXEL_COUNT_DEFAULT;
   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_TICKS = 136;
   localparam int MAX_REPORTS  = 10;
   localparam int WATCHDOG     = 4_000_000;
   localparam int COLOR_W      = $bits(color_type);

   // rainbow colors packed red/green/blue, entry 0 in the low bits:
   // red, orange, yellow, green, blue, cyan, magenta, purple
   localparam logic [8*COLOR_W-1:0] SPECTRUM = {
      21'h1FC045, 21'h1FC07F, 21'h003FFF, 21'h00007F,
      21'h003F80, 21'h1FFF80, 21'h1FD000, 21'h1FC000
   };

   // one pixel as seen on the result channel
   typedef struct packed {
      logic [INDEX_OUT_W-1:0] index;
      logic [CHAN_W-1:0]      red;
      logic [CHAN_W-1:0]      green;
      logic [CHAN_W-1:0]      blue;
      logic                   last;
   } pixel_type;

   logic                  clock = 1'b1;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lsp_req_if req_bus ();
   lsp_rsp_if rsp_bus ();

   led_strip_pattern_engine_core #(.PIXEL_COUNT(PIXELS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // software image of the registers and the animation state
   logic [MODE_W-1:0] cfg_mode;
   color_type         cfg_primary;
   color_type         cfg_secondary;
   color_type         frame [PIXELS] = '{default: COLOR_BLACK};
   bit                strobe_on = 1'b0;
   color_type         fade_goal = COLOR_BLACK;
   bit                restart_armed = 1'b0;
   int                wipe_pos = 0;
   logic [2:0]        hue_offset = 3'd0;

   // ticks waiting to be sent and pixels waiting to be seen
   bit        pending_ticks [$];
   pixel_type expected_pixels [$];
   int        requests_queued = 0;
   int        requests_sent = 0;
   int        requests_accepted = 0;
   int        mismatch_count = 0;
   int        sender_idle_pct;
   int        receiver_idle_pct;

   always begin
      #HALF_PERIOD clock = ~clock;
   end

   // one channel step of fade and two color: move by 2, clamp at the goal
   function automatic logic [CHAN_W-1:0] approach(input logic [CHAN_W-1:0] cur,
                                                  input logic [CHAN_W-1:0] goal);
      int c;
      int g;
      c = cur;
      g = goal;
      if (c + 2 < g) begin
         return CHAN_W'(c + 2);
      end else if (c > g + 2) begin
         return CHAN_W'(c - 2);
      end
      return goal;
   endfunction

   // channel level, weighted toward the extremes; gentle keeps fades short
   function automatic logic [CHAN_W-1:0] pick_level(input bit gentle);
      if (gentle && $urandom_range(0, 9) < 7) begin
         return CHAN_W'($urandom_range(0, 12));
      end
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return CHAN_W'($urandom_range(0, 9));
         default: return CHAN_W'($urandom_range(0, 127));
      endcase
   endfunction

   // advance the frame image by one tick and queue the pixels it shows
   task automatic render_tick(input logic restart);
      color_type first;
      color_type second;
      color_type next;
      color_type shown;
      bit        lit;
      int        lit_idx;
      int        p;
      lit     = 1'b0;
      lit_idx = 0;
      // a restart request is latched before the pattern runs
      if (restart) begin
         restart_armed = 1'b1;
      end
      case (cfg_mode)
         PAT_BLANK: begin
            foreach (frame[i]) frame[i] = COLOR_BLACK;
         end
         PAT_SOLID: begin
            foreach (frame[i]) frame[i] = cfg_primary;
         end
         PAT_FLASH: begin
            foreach (frame[i]) frame[i] = strobe_on ? cfg_primary : COLOR_BLACK;
            strobe_on = !strobe_on;
         end
         PAT_FADE, PAT_DUAL: begin
            first  = cfg_primary;
            second = (cfg_mode == PAT_FADE) ? COLOR_BLACK : cfg_secondary;
            // pending restart reloads the primary color and aims at the second
            if (restart_armed) begin
               restart_armed = 1'b0;
               fade_goal     = second;
               foreach (frame[i]) frame[i] = first;
            end
            next.red   = approach(frame[0].red, fade_goal.red);
            next.green = approach(frame[0].green, fade_goal.green);
            next.blue  = approach(frame[0].blue, fade_goal.blue);
            foreach (frame[i]) frame[i] = next;
            // goal reached: swap toward the other color
            if (next == fade_goal) begin
               fade_goal = (fade_goal == first) ? second : first;
            end
         end
         PAT_WIPE_DOWN, PAT_WIPE_UP: begin
            if (wipe_pos == 0) begin
               foreach (frame[i]) frame[i] = COLOR_BLACK;
            end
            lit     = 1'b1;
            lit_idx = (cfg_mode == PAT_WIPE_DOWN) ? wipe_pos : PIXELS - 1 - wipe_pos;
            // shown in primary this tick, left black in the store
            frame[lit_idx] = COLOR_BLACK;
            wipe_pos       = (wipe_pos == PIXELS - 1) ? 0 : wipe_pos + 1;
         end
         PAT_RAINBOW: begin
            for (int i = 0; i < PIXELS; i++) begin
               frame[i] = SPECTRUM[((int'(hue_offset) + i) & 7) * COLOR_W +: COLOR_W];
            end
            hue_offset = hue_offset + 3'(PIXELS - 1);
         end
         PAT_BANDS: begin
            // magenta, purple, blue bands; leftover pixels keep their color
            p = 0;
            for (int i = 0; i < (3 * PIXELS) / 8; i++) begin
               frame[p] = COLOR_MAGENTA;
               p++;
            end
            for (int i = 0; i < PIXELS / 4; i++) begin
               frame[p] = COLOR_PURPLE;
               p++;
            end
            for (int i = 0; i < (3 * PIXELS) / 8; i++) begin
               frame[p] = COLOR_BLUE;
               p++;
            end
         end
         default: begin
            // undefined mode: store and state untouched, frame replayed
         end
      endcase
      for (int i = 0; i < PIXELS; i++) begin
         shown = (lit && i == lit_idx) ? cfg_primary : frame[i];
         expected_pixels.push_back('{index: INDEX_OUT_W'(i), red: shown.red,
                                    green: shown.green, blue: shown.blue,
                                    last: (i == PIXELS - 1)});
      end
   endtask

   // apb write: setup phase, access phase until pready, then back to idle
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_MODE:            cfg_mode            = value[MODE_W-1:0];
         REG_PRIMARY_RED:     cfg_primary.red     = value[CHAN_W-1:0];
         REG_PRIMARY_GREEN:   cfg_primary.green   = value[CHAN_W-1:0];
         REG_PRIMARY_BLUE:    cfg_primary.blue    = value[CHAN_W-1:0];
         REG_SECONDARY_RED:   cfg_secondary.red   = value[CHAN_W-1:0];
         REG_SECONDARY_GREEN: cfg_secondary.green = value[CHAN_W-1:0];
         REG_SECONDARY_BLUE:  cfg_secondary.blue  = value[CHAN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic push_tick(input bit restart);
      pending_ticks.push_back(restart);
      requests_queued++;
   endtask

   // hold off new ticks until every queued request is taken and every pixel seen
   task automatic wait_idle();
      do @(negedge clock);
      while (requests_accepted != requests_queued || expected_pixels.size() != 0);
   endtask

   // request driver: valid holds until taken, random gaps between requests
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.restart <= 1'b0;
      end else if (!req_bus.valid || requests_accepted == requests_sent) begin
         if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_bus.valid   <= 1'b1;
            req_bus.restart <= pending_ticks.pop_front();
            requests_sent++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result channel back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // accepted request: run the frame image forward
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         requests_accepted++;
         render_tick(req_bus.restart);
      end
   end

   // accepted pixel: compare against the oldest expectation
   always @(posedge clock) begin : pixel_check
      pixel_type seen;
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '{index: rsp_bus.pixel_index, red: rsp_bus.red, green: rsp_bus.green,
                  blue: rsp_bus.blue, last: rsp_bus.last_pixel};
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: unexpected pixel idx %0d rgb %0d/%0d/%0d last %0b", $realtime,
                        seen.index, seen.red, seen.green, seen.blue, seen.last);
            end
         end else begin
            want = expected_pixels.pop_front();
            if (seen.index != want.index || seen.red != want.red ||
                seen.green != want.green || seen.blue != want.blue ||
                seen.last != want.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: pixel mismatch exp idx %0d rgb %0d/%0d/%0d last %0b", $realtime,
                           want.index, want.red, want.green, want.blue, want.last);
                  $display("%0t:                act idx %0d rgb %0d/%0d/%0d last %0b", $realtime,
                           seen.index, seen.red, seen.green, seen.blue, seen.last);
               end
            end
         end
      end
   end

   initial begin : stimulus
      int              random_ticks;
      int              seg_len;
      int              pick;
      bit              fading;
      logic [MODE_W-1:0] mode_val;

      // every input known before the first clock edge
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      sender_idle_pct   = 28;
      receiver_idle_pct = 82;

      // register reset values
      cfg_mode      = PAT_SOLID;
      cfg_primary   = '{red: 7'h7F, green: 7'h00, blue: 7'h00};
      cfg_secondary = '{red: 7'h00, green: 7'h7F, blue: 7'h7F};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, restart left armed for the fade below
      push_tick(1'b0);
      push_tick(1'b1);
      wait_idle();

      csr_write(REG_MODE, CSR_DATA_W'(PAT_BLANK));
      push_tick(1'b0);
      wait_idle();

      // strobe starts dark, then toggles
      csr_write(REG_MODE, CSR_DATA_W'(PAT_FLASH));
      repeat (3) push_tick(1'b0);
      wait_idle();

      // fade: the armed restart is consumed first, channels clamp near black
      csr_write(REG_PRIMARY_RED, 1);
      csr_write(REG_PRIMARY_GREEN, 126);
      csr_write(REG_PRIMARY_BLUE, 3);
      csr_write(REG_MODE, CSR_DATA_W'(PAT_FADE));
      push_tick(1'b0);
      push_tick(1'b0);
      push_tick(1'b1);
      wait_idle();

      // two color one clamp step apart: target swaps on every tick
      csr_write(REG_SECONDARY_RED, 0);
      csr_write(REG_SECONDARY_GREEN, 127);
      csr_write(REG_SECONDARY_BLUE, 2);
      csr_write(REG_MODE, CSR_DATA_W'(PAT_DUAL));
      push_tick(1'b1);
      push_tick(1'b0);
      push_tick(1'b0);
      wait_idle();

      // wipes over whatever the store holds
      csr_write(REG_PRIMARY_RED, 127);
      csr_write(REG_PRIMARY_GREEN, 0);
      csr_write(REG_PRIMARY_BLUE, 127);
      csr_write(REG_MODE, CSR_DATA_W'(PAT_WIPE_DOWN));
      repeat (3) push_tick(1'b0);
      wait_idle();
      csr_write(REG_MODE, CSR_DATA_W'(PAT_WIPE_UP));
      repeat (2) push_tick(1'b0);
      wait_idle();

      csr_write(REG_MODE, CSR_DATA_W'(PAT_RAINBOW));
      repeat (2) push_tick(1'b0);
      wait_idle();
      csr_write(REG_MODE, CSR_DATA_W'(PAT_BANDS));
      push_tick(1'b0);
      wait_idle();

      // undefined modes replay the store; restart stays armed
      csr_write(REG_MODE, (1 << MODE_W) - 1);
      push_tick(1'b1);
      push_tick(1'b0);
      wait_idle();
      csr_write(REG_MODE, PAT_BANDS + 1);
      push_tick(1'b0);
      wait_idle();

      // random bursts, each under its own settings, about half of them fade sequences
      random_ticks = 0;
      while (random_ticks < RANDOM_TICKS) begin
         if (random_ticks >= (2 * RANDOM_TICKS) / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else if (random_ticks >= RANDOM_TICKS / 3) begin
            sender_idle_pct   = 82;
            receiver_idle_pct = 28;
         end
         pick = $urandom_range(0, 19);
         case (pick)
            0, 1, 2, 3, 4: mode_val = PAT_FADE;
            5, 6, 7, 8, 9: mode_val = PAT_DUAL;
            10:            mode_val = PAT_BLANK;
            11:            mode_val = PAT_SOLID;
            12, 13:        mode_val = PAT_FLASH;
            14, 18:        mode_val = PAT_WIPE_DOWN;
            15:            mode_val = PAT_WIPE_UP;
            16:            mode_val = PAT_RAINBOW;
            17:            mode_val = PAT_BANDS;
            default:       mode_val = MODE_W'($urandom_range(PAT_BANDS + 1, (1 << MODE_W) - 1));
         endcase
         fading = (mode_val == PAT_FADE || mode_val == PAT_DUAL);
         for (int k = REG_PRIMARY_RED; k <= REG_SECONDARY_BLUE; k++) begin
            if ($urandom_range(0, 9) < 6) begin
               csr_write(csr_index_type'(k), CSR_DATA_W'(pick_level(fading)));
            end
         end
         csr_write(REG_MODE, CSR_DATA_W'(mode_val));
         seg_len = fading ? $urandom_range(8, 30) : $urandom_range(4, 14);
         if (seg_len > RANDOM_TICKS - random_ticks) begin
            seg_len = RANDOM_TICKS - random_ticks;
         end
         // a fade sequence usually opens with a restart
         push_tick(fading ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0));
         for (int n = 1; n < seg_len; n++) begin
            push_tick($urandom_range(0, 11) == 0);
         end
         random_ticks += seg_len;
         wait_idle();
      end

      wait_idle();
      repeat (3 * (PIXELS + 2)) @(negedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("** led_strip_pattern_engine_core: PASSED **");
      end else begin
         $display("** led_strip_pattern_engine_core: FAILED **");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #WATCHDOG;
      $display("** led_strip_pattern_engine_core: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
rtl/lsp_pkg.sv
rtl/lsp_req_if.sv
rtl/lsp_rsp_if.sv
rtl/lsp_csr.sv
rtl/lsp_front.sv
rtl/lsp_back.sv
rtl/led_strip_pattern_engine_core.sv
tb/sv/testbench.sv
